// ===== rtl/qht_pkg.sv =====
package qht_pkg;

  // miss cause codes
  localparam logic [1:0] CAUSE_HIT     = 2'd0;
  localparam logic [1:0] CAUSE_OUTSIDE = 2'd1;
  localparam logic [1:0] CAUSE_EDGE_ON = 2'd2;

  localparam int NUM_CORNERS = 4;
  localparam int QUOT_BITS   = 32;

  // configuration register indexes
  localparam logic [7:0] REG_CORNER_A = 8'd0;
  localparam logic [7:0] REG_CORNER_B = 8'd1;
  localparam logic [7:0] REG_CORNER_C = 8'd2;
  localparam logic [7:0] REG_CORNER_D = 8'd3;

  // quad geometry derived from the corner registers
  typedef struct packed {
    logic [3:0][15:0]   vx;
    logic [3:0][15:0]   vy;
    logic signed [31:0] z0;
    logic signed [16:0] e1x;
    logic signed [16:0] e1y;
    logic signed [32:0] e1z;
    logic signed [16:0] e2x;
    logic signed [16:0] e2y;
    logic signed [32:0] e2z;
    logic signed [34:0] nz;
    logic [35:0]        nz_mag;
  } geom_t;

  // classified item passed from front to back
  typedef struct packed {
    logic               outside;
    logic signed [34:0] c1;
    logic signed [34:0] c2;
  } item_t;

endpackage

// ===== rtl/quad_hit_test_with_depth.sv =====
// channel   direction  handshake                 payload
// point     in         push / full               point_x, point_y
// result    out        pop / empty               hit, miss_cause, depth
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one point a cycle unless stalled; every point pushed while not full gives one result
// the path is 3 front stages, 1 queue slot and 37 back stages (32 of them
// the divider, one quotient bit each)
// reset clears corners to zero and empties all stages and the queue
// a held result stalls the back; a full queue stalls the front and raises full
module quad_hit_test_with_depth #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic [1:0]         miss_cause,
  output logic signed [31:0] depth,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  qht_pkg::geom_t geom;
  qht_pkg::item_t fq_item, qb_item;
  logic           fq_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  qht_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .geom     (geom)
  );

  qht_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .point_x (point_x),
    .point_y (point_y),
    .geom    (geom),
    .q_push  (fq_push),
    .q_item  (fq_item),
    .q_full  (q_full)
  );

  qht_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (fq_push),
    .wr_item  (fq_item),
    .is_full  (q_full),
    .rd       (q_pop),
    .rd_item  (qb_item),
    .is_empty (q_empty)
  );

  qht_back u_back (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .q_empty    (q_empty),
    .q_item     (qb_item),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .hit        (hit),
    .miss_cause (miss_cause),
    .depth      (depth)
  );

  // a miss carries zero depth
  a_miss_depth: assert property (@(posedge clk) disable iff (rst)
    !empty && miss_cause != qht_pkg::CAUSE_HIT |-> depth == '0)
    else $error("miss with non-zero depth");

  // hit flag agrees with cause
  a_hit_cause: assert property (@(posedge clk) disable iff (rst)
    !empty |-> hit == (miss_cause == qht_pkg::CAUSE_HIT))
    else $error("hit flag disagrees with cause");

  // back never reads an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // nothing shows right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result present after reset");

endmodule

// ===== rtl/qht_cfg.sv =====
module qht_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [7:0]         wr_index,
  input  logic [63:0]        wr_data,
  output qht_pkg::geom_t     geom
);

  logic [3:0][63:0]   corner;
  logic signed [16:0] e1x, e1y, e2x, e2y;
  logic signed [32:0] e1z, e2z;
  logic signed [33:0] p1, p2;
  logic signed [34:0] nz;
  logic [35:0]        nz_mag;

  // corner registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= '0;
    end else if (wr_en) begin
      case (wr_index)
        qht_pkg::REG_CORNER_A: corner[0] <= wr_data;
        qht_pkg::REG_CORNER_B: corner[1] <= wr_data;
        qht_pkg::REG_CORNER_C: corner[2] <= wr_data;
        qht_pkg::REG_CORNER_D: corner[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // edge vectors, normal z and its magnitude
  always_ff @(posedge clk) begin
    e1x    <= 17'($signed(corner[1][15:0]))  - 17'($signed(corner[0][15:0]));
    e1y    <= 17'($signed(corner[1][31:16])) - 17'($signed(corner[0][31:16]));
    e1z    <= 33'($signed(corner[1][63:32])) - 33'($signed(corner[0][63:32]));
    e2x    <= 17'($signed(corner[2][15:0]))  - 17'($signed(corner[0][15:0]));
    e2y    <= 17'($signed(corner[2][31:16])) - 17'($signed(corner[0][31:16]));
    e2z    <= 33'($signed(corner[2][63:32])) - 33'($signed(corner[0][63:32]));
    p1     <= e1x * e2y;
    p2     <= e1y * e2x;
    nz     <= 35'(p1) - 35'(p2);
    nz_mag <= nz[34] ? 36'(-nz) : 36'(nz);
  end

  always_comb begin
    for (int i = 0; i < qht_pkg::NUM_CORNERS; i++) begin
      geom.vx[i] = corner[i][15:0];
      geom.vy[i] = corner[i][31:16];
    end
    geom.z0     = $signed(corner[0][63:32]);
    geom.e1x    = e1x;
    geom.e1y    = e1y;
    geom.e1z    = e1z;
    geom.e2x    = e2x;
    geom.e2y    = e2y;
    geom.e2z    = e2z;
    geom.nz     = nz;
    geom.nz_mag = nz_mag;
  end

endmodule

// ===== rtl/qht_front.sv =====
module qht_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  qht_pkg::geom_t     geom,
  output logic               q_push,
  output qht_pkg::item_t     q_item,
  input  logic               q_full
);

  logic               en;
  logic               f0_valid, f1_valid, f2_valid;
  logic signed [15:0] f0_px, f0_py;
  logic signed [33:0] f1_pab [4];
  logic signed [33:0] f1_pba [4];
  logic signed [33:0] f1_c1a, f1_c1b, f1_c2a, f1_c2b;
  logic signed [16:0] ax [4];
  logic signed [16:0] ay [4];
  logic signed [16:0] dx, dy;
  logic signed [34:0] cr [4];
  logic [3:0]         pos;
  qht_pkg::item_t     f2_item;

  assign en   = !q_full;
  assign full = q_full;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f0_valid <= push;
      f1_valid <= f0_valid;
      f2_valid <= f1_valid;
    end
  end

  // corner-to-point vectors
  always_comb begin
    for (int i = 0; i < qht_pkg::NUM_CORNERS; i++) begin
      ax[i] = 17'($signed(geom.vx[i])) - 17'(f0_px);
      ay[i] = 17'($signed(geom.vy[i])) - 17'(f0_py);
    end
    dx = 17'(f0_px) - 17'($signed(geom.vx[0]));
    dy = 17'(f0_py) - 17'($signed(geom.vy[0]));
  end

  // stage 0 capture, stage 1 products
  always_ff @(posedge clk) begin
    if (en) begin
      f0_px <= point_x;
      f0_py <= point_y;
      for (int i = 0; i < qht_pkg::NUM_CORNERS; i++) begin
        f1_pab[i] <= ax[i] * ay[(i + 1) % 4];
        f1_pba[i] <= ay[i] * ax[(i + 1) % 4];
      end
      f1_c1a <= geom.e1y * dx;
      f1_c1b <= geom.e1x * dy;
      f1_c2a <= geom.e2x * dy;
      f1_c2b <= geom.e2y * dx;
    end
  end

  // edge tests, zero counts as inside
  always_comb begin
    for (int i = 0; i < qht_pkg::NUM_CORNERS; i++) begin
      cr[i]  = 35'(f1_pab[i]) - 35'(f1_pba[i]);
      pos[i] = !cr[i][34] && (cr[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_item.outside <= |pos;
      f2_item.c1      <= 35'(f1_c1a) - 35'(f1_c1b);
      f2_item.c2      <= 35'(f1_c2a) - 35'(f1_c2b);
    end
  end

  assign q_push = en && f2_valid;
  assign q_item = f2_item;

endmodule

// ===== rtl/qht_queue.sv =====
module qht_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  qht_pkg::item_t wr_item,
  output logic           is_full,
  input  logic           rd,
  output qht_pkg::item_t rd_item,
  output logic           is_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qht_pkg::item_t slot [DEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [CW-1:0]  count;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign rd_item  = slot[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wptr] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/qht_back.sv =====
module qht_back (
  input  logic               clk,
  input  logic               rst,
  input  qht_pkg::geom_t     geom,
  input  logic               q_empty,
  input  qht_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic               hit,
  output logic [1:0]         miss_cause,
  output logic signed [31:0] depth
);

  localparam int NQ = qht_pkg::QUOT_BITS;

  logic               en;
  logic               o_valid;
  logic               s0_valid, s1_valid, s2_valid;
  qht_pkg::item_t     s0_item;
  logic [1:0]         s1_cause, s2_cause;
  logic signed [66:0] s1_pa;
  logic signed [67:0] s1_pb, s1_pc;
  logic signed [69:0] s2_t;
  logic [69:0]        mag;

  logic               d_valid [NQ+1];
  logic [1:0]         d_cause [NQ+1];
  logic               d_neg   [NQ+1];
  logic               d_sat   [NQ+1];
  logic [35:0]        d_rem   [NQ+1];
  logic [NQ-1:0]      d_low   [NQ+1];
  logic [NQ-1:0]      d_q     [NQ+1];
  logic [NQ-1:0]      qf;

  assign en    = !o_valid || pop;
  assign q_pop = en && !q_empty;
  assign empty = !o_valid;

  // valid bits of the early stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      d_valid[0] <= 1'b0;
    end else if (en) begin
      s0_valid   <= !q_empty;
      s1_valid   <= s0_valid;
      s2_valid   <= s1_valid;
      d_valid[0] <= s2_valid;
    end
  end

  assign mag = s2_t[69] ? 70'(-s2_t) : 70'(s2_t);

  // plane numerator, sign and magnitude, divider set-up
  always_ff @(posedge clk) begin
    if (en) begin
      s0_item  <= q_item;
      s1_cause <= s0_item.outside ? qht_pkg::CAUSE_OUTSIDE :
                  (geom.nz == '0) ? qht_pkg::CAUSE_EDGE_ON : qht_pkg::CAUSE_HIT;
      s1_pa    <= geom.z0 * geom.nz;
      s1_pb    <= geom.e2z * s0_item.c1;
      s1_pc    <= geom.e1z * s0_item.c2;
      s2_cause <= s1_cause;
      s2_t     <= 70'(s1_pa) - 70'(s1_pb) - 70'(s1_pc);
      d_cause[0] <= s2_cause;
      d_neg[0]   <= s2_t[69] ^ geom.nz[34];
      d_sat[0]   <= mag[69:32] >= 38'(geom.nz_mag);
      d_rem[0]   <= mag[67:32];
      d_low[0]   <= mag[31:0];
      d_q[0]     <= '0;
    end
  end

  // restoring divider, one quotient bit a stage
  for (genvar k = 0; k < NQ; k++) begin : g_div
    logic [36:0] r2;
    logic        ge;

    always_comb begin
      r2 = {d_rem[k], d_low[k][NQ-1]};
      ge = r2 >= {1'b0, geom.nz_mag};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k+1] <= 1'b0;
      end else if (en) begin
        d_valid[k+1] <= d_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_cause[k+1] <= d_cause[k];
        d_neg[k+1]   <= d_neg[k];
        d_sat[k+1]   <= d_sat[k];
        d_rem[k+1]   <= ge ? 36'(r2 - {1'b0, geom.nz_mag}) : r2[35:0];
        d_low[k+1]   <= {d_low[k][NQ-2:0], 1'b0};
        d_q[k+1]     <= {d_q[k][NQ-2:0], ge};
      end
    end
  end

  assign qf = d_q[NQ];

  // output register with sign and saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= d_valid[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss_cause <= d_cause[NQ];
      hit        <= (d_cause[NQ] == qht_pkg::CAUSE_HIT);
      if (d_cause[NQ] != qht_pkg::CAUSE_HIT) begin
        depth <= '0;
      end else if (d_neg[NQ]) begin
        depth <= (d_sat[NQ] || qf > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-qf);
      end else begin
        depth <= (d_sat[NQ] || qf > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qf);
      end
    end
  end

endmodule
